@@ rtl/core/ffa_pkg.sv @@
// Shared types and constants of the first-fit heap allocator.
package ffa_pkg;

   localparam int HEADER_BYTES = 16;
   localparam int MAX_CHUNKS   = 256;
   localparam int IDX_W        = $clog2(MAX_CHUNKS);
   localparam int CNT_W        = IDX_W + 1;
   localparam int ARENA_MAX    = 65536;
   localparam int ARENA_MIN    = HEADER_BYTES + 1;
   localparam int THR_RESET    = 4096;

   localparam logic CSR_ARENA_LENGTH    = 1'b0;
   localparam logic CSR_LARGE_THRESHOLD = 1'b1;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   typedef struct packed {
      logic        used;
      logic [15:0] len;
      logic [15:0] off;
   } chunk_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_FIT   = 2'd1,
      ST_BAD_FREE = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD,
      S_EV,
      S_INS_RD,
      S_INS_WR,
      S_W0,
      S_W1,
      S_NB_R,
      S_NB_L,
      S_NB_E,
      S_MRG_W,
      S_DEL_RD,
      S_DEL_WR,
      S_DONE
   } state_type;

endpackage

@@ rtl/core/ffa_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module ffa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ rtl/core/first_fit_heap_allocator_unit.sv @@
// First-fit heap allocator: top level with chunk table sequencer and result register.
//
// The chunk table lives in one 256-entry RAM, address-ordered. Each request
// is handled one at a time. A search visits one entry at a time, with a RAM
// read and then an evaluate step per entry. A split moves every entry above
// the carved one up by one slot, and a merge moves the entries above it
// down, each entry with a RAM read and then a write, before the response
// is handed off. After reset or a write of arena_length the table is rebuilt
// with a single write before the next request is taken.
module first_fit_heap_allocator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // size[15:0], address[31:16]
   input  logic        req_tuser,   // func[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // payload_offset[15:0], free_bytes[32:16], zero[39:33]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [16:0] csr_wdata
);
   import ffa_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [16:0]      free_ff, free_in;
   logic [16:0]      arena_ff, arena_in;
   logic [16:0]      thr_ff, thr_in;
   logic             rebuild_ff, rebuild_in;
   logic             func_ff, func_in;
   logic [15:0]      size_ff, size_in;
   logic [15:0]      addr_ff, addr_in;
   logic             back_ff, back_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] j_ff, j_in;
   chunk_type        e0_ff, e0_in, e1_ff, e1_in;
   logic [15:0]      cur_off_ff, cur_off_in, cur_len_ff, cur_len_in;
   logic             rgt_ok_ff, rgt_ok_in, lft_ok_ff, lft_ok_in;
   logic             rmrg_ff, rmrg_in, lmrg_ff, lmrg_in;
   logic [15:0]      rlen_ff, rlen_in, loff_ff, loff_in, llen_ff, llen_in;
   status_type       stat_ff, stat_in;
   logic [15:0]      pay_ff, pay_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      rsp_pay_ff, rsp_pay_in;
   status_type       rsp_stat_ff, rsp_stat_in;
   logic [16:0]      rsp_free_ff, rsp_free_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   chunk_type        wr_data, rd_data;

   logic [17:0]      need, lenx, pay_split, pay_exact;
   logic             split_ok, exact_ok;
   logic [16:0]      base_len, mrg_len;
   logic [1:0]       del_n;
   logic [16:0]      clamp_val;

   ffa_ram #(.WIDTH($bits(chunk_type)), .DEPTH(MAX_CHUNKS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == S_IDLE) && !rebuild_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_free_ff, rsp_pay_ff};
   assign rsp_tuser  = rsp_stat_ff;

   always_comb begin
      if (csr_wdata > 17'(ARENA_MAX)) begin
         clamp_val = 17'(ARENA_MAX);
      end else if (csr_wdata < 17'(ARENA_MIN)) begin
         clamp_val = 17'(ARENA_MIN);
      end else begin
         clamp_val = csr_wdata;
      end

      need      = {2'b0, size_ff} + 18'(HEADER_BYTES + 1);
      lenx      = {2'b0, rd_data.len};
      pay_exact = {2'b0, rd_data.off} + 18'(HEADER_BYTES);
      if (back_ff) begin
         pay_split = {2'b0, rd_data.off} + lenx - {2'b0, size_ff} + 18'(HEADER_BYTES);
      end else begin
         pay_split = pay_exact;
      end
      split_ok = !rd_data.used && (lenx >= need) && (pay_split <= 18'hFFFF);
      exact_ok = !rd_data.used && !(lenx >= need) && (rd_data.len == size_ff)
                 && (pay_exact <= 18'hFFFF);

      base_len = {1'b0, cur_len_ff};
      if (rmrg_ff) begin
         base_len = base_len + {1'b0, rlen_ff} + 17'(HEADER_BYTES);
      end
      mrg_len = {1'b0, llen_ff} + base_len + 17'(HEADER_BYTES);
      del_n   = {1'b0, rmrg_ff} + {1'b0, lmrg_ff};

      state_in     = state_ff;
      count_in     = count_ff;
      free_in      = free_ff;
      arena_in     = arena_ff;
      thr_in       = thr_ff;
      rebuild_in   = rebuild_ff;
      func_in      = func_ff;
      size_in      = size_ff;
      addr_in      = addr_ff;
      back_in      = back_ff;
      idx_in       = idx_ff;
      rem_in       = rem_ff;
      j_in         = j_ff;
      e0_in        = e0_ff;
      e1_in        = e1_ff;
      cur_off_in   = cur_off_ff;
      cur_len_in   = cur_len_ff;
      rgt_ok_in    = rgt_ok_ff;
      lft_ok_in    = lft_ok_ff;
      rmrg_in      = rmrg_ff;
      lmrg_in      = lmrg_ff;
      rlen_in      = rlen_ff;
      loff_in      = loff_ff;
      llen_in      = llen_ff;
      stat_in      = stat_ff;
      pay_in       = pay_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pay_in   = rsp_pay_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_free_in  = rsp_free_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = e0_ff;
      rd_addr      = idx_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (rebuild_ff) begin
               wr_en       = 1'b1;
               wr_addr     = '0;
               wr_data.off = '0;
               wr_data.len = 16'(arena_ff - 17'(HEADER_BYTES));
               wr_data.used = 1'b0;
               count_in    = CNT_W'(1);
               free_in     = arena_ff - 17'(HEADER_BYTES);
               rebuild_in  = 1'b0;
            end else if (req_tvalid) begin
               func_in = req_tuser;
               size_in = req_tdata[15:0];
               addr_in = req_tdata[31:16];
               back_in = (req_tuser == FUNC_ALLOC) && ({1'b0, req_tdata[15:0]} >= thr_ff);
               rem_in  = count_ff;
               if ((req_tuser == FUNC_ALLOC) && ({1'b0, req_tdata[15:0]} >= thr_ff)) begin
                  idx_in = IDX_W'(count_ff - CNT_W'(1));
               end else begin
                  idx_in = '0;
               end
               state_in = S_RD;
            end
            if (csr_we) begin
               if (csr_index == CSR_ARENA_LENGTH) begin
                  arena_in   = clamp_val;
                  rebuild_in = 1'b1;
               end else begin
                  thr_in = csr_wdata;
               end
            end
         end
         S_RD: begin
            rd_addr  = idx_ff;
            state_in = S_EV;
         end
         S_EV: begin
            state_in = S_RD;
            if (back_ff) begin
               idx_in = idx_ff - IDX_W'(1);
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
            rem_in = rem_ff - CNT_W'(1);
            if (rem_ff == CNT_W'(1)) begin
               stat_in  = (func_ff == FUNC_FREE) ? ST_BAD_FREE : ST_NO_FIT;
               pay_in   = '0;
               state_in = S_DONE;
            end
            if (func_ff == FUNC_FREE) begin
               if (rd_data.used && ({1'b0, rd_data.off} + 17'(HEADER_BYTES) == {1'b0, addr_ff}))
               begin
                  idx_in     = idx_ff;
                  cur_off_in = rd_data.off;
                  cur_len_in = rd_data.len;
                  free_in    = free_ff + {1'b0, rd_data.len};
                  rgt_ok_in  = ({1'b0, idx_ff} + CNT_W'(1)) < count_ff;
                  lft_ok_in  = idx_ff != '0;
                  stat_in    = ST_OK;
                  pay_in     = '0;
                  state_in   = S_NB_R;
               end
            end else if (split_ok) begin
               idx_in = idx_ff;
               if (count_ff == CNT_W'(MAX_CHUNKS)) begin
                  stat_in  = ST_FULL;
                  pay_in   = '0;
                  state_in = S_DONE;
               end else begin
                  e0_in.off = rd_data.off;
                  if (back_ff) begin
                     e0_in.len  = rd_data.len - size_ff - 16'(HEADER_BYTES);
                     e0_in.used = 1'b0;
                     e1_in.off  = 16'(pay_split - 18'(HEADER_BYTES));
                     e1_in.len  = size_ff;
                     e1_in.used = 1'b1;
                  end else begin
                     e0_in.len  = size_ff;
                     e0_in.used = 1'b1;
                     e1_in.off  = rd_data.off + 16'(HEADER_BYTES) + size_ff;
                     e1_in.len  = rd_data.len - size_ff - 16'(HEADER_BYTES);
                     e1_in.used = 1'b0;
                  end
                  free_in  = free_ff - {1'b0, size_ff} - 17'(HEADER_BYTES);
                  stat_in  = ST_OK;
                  pay_in   = pay_split[15:0];
                  j_in     = count_ff - CNT_W'(1);
                  state_in = S_INS_RD;
               end
            end else if (exact_ok) begin
               idx_in       = idx_ff;
               wr_en        = 1'b1;
               wr_addr      = idx_ff;
               wr_data      = rd_data;
               wr_data.used = 1'b1;
               free_in      = free_ff - {1'b0, rd_data.len};
               stat_in      = ST_OK;
               pay_in       = pay_exact[15:0];
               state_in     = S_DONE;
            end
         end
         S_INS_RD: begin
            rd_addr = j_ff[IDX_W-1:0];
            if (j_ff > {1'b0, idx_ff}) begin
               state_in = S_INS_WR;
            end else begin
               state_in = S_W0;
            end
         end
         S_INS_WR: begin
            wr_en    = 1'b1;
            wr_addr  = j_ff[IDX_W-1:0] + IDX_W'(1);
            wr_data  = rd_data;
            j_in     = j_ff - CNT_W'(1);
            state_in = S_INS_RD;
         end
         S_W0: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = e0_ff;
            state_in = S_W1;
         end
         S_W1: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff + IDX_W'(1);
            wr_data  = e1_ff;
            count_in = count_ff + CNT_W'(1);
            state_in = S_DONE;
         end
         S_NB_R: begin
            rd_addr  = idx_ff + IDX_W'(1);
            state_in = S_NB_L;
         end
         S_NB_L: begin
            rmrg_in  = rgt_ok_ff && !rd_data.used;
            rlen_in  = rd_data.len;
            rd_addr  = idx_ff - IDX_W'(1);
            state_in = S_NB_E;
         end
         S_NB_E: begin
            lmrg_in  = lft_ok_ff && !rd_data.used;
            loff_in  = rd_data.off;
            llen_in  = rd_data.len;
            state_in = S_MRG_W;
         end
         S_MRG_W: begin
            wr_en        = 1'b1;
            wr_data.used = 1'b0;
            if (lmrg_ff) begin
               wr_addr     = idx_ff - IDX_W'(1);
               wr_data.off = loff_ff;
               wr_data.len = mrg_len[15:0];
            end else begin
               wr_addr     = idx_ff;
               wr_data.off = cur_off_ff;
               wr_data.len = base_len[15:0];
            end
            free_in = free_ff + 17'(HEADER_BYTES) * {15'd0, del_n};
            j_in    = {1'b0, idx_ff} + CNT_W'(1) + CNT_W'(rmrg_ff);
            if (del_n == 2'd0) begin
               state_in = S_DONE;
            end else begin
               state_in = S_DEL_RD;
            end
         end
         S_DEL_RD: begin
            rd_addr = j_ff[IDX_W-1:0];
            if (j_ff < count_ff) begin
               state_in = S_DEL_WR;
            end else begin
               count_in = count_ff - CNT_W'(del_n);
               state_in = S_DONE;
            end
         end
         S_DEL_WR: begin
            wr_en    = 1'b1;
            wr_addr  = IDX_W'(j_ff - CNT_W'(del_n));
            wr_data  = rd_data;
            j_in     = j_ff + CNT_W'(1);
            state_in = S_DEL_RD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_pay_in   = pay_ff;
               rsp_stat_in  = stat_ff;
               rsp_free_in  = free_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= CNT_W'(1);
         free_ff      <= 17'(ARENA_MAX - HEADER_BYTES);
         arena_ff     <= 17'(ARENA_MAX);
         thr_ff       <= 17'(THR_RESET);
         rebuild_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         free_ff      <= free_in;
         arena_ff     <= arena_in;
         thr_ff       <= thr_in;
         rebuild_ff   <= rebuild_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      size_ff     <= size_in;
      addr_ff     <= addr_in;
      back_ff     <= back_in;
      idx_ff      <= idx_in;
      rem_ff      <= rem_in;
      j_ff        <= j_in;
      e0_ff       <= e0_in;
      e1_ff       <= e1_in;
      cur_off_ff  <= cur_off_in;
      cur_len_ff  <= cur_len_in;
      rgt_ok_ff   <= rgt_ok_in;
      lft_ok_ff   <= lft_ok_in;
      rmrg_ff     <= rmrg_in;
      lmrg_ff     <= lmrg_in;
      rlen_ff     <= rlen_in;
      loff_ff     <= loff_in;
      llen_ff     <= llen_in;
      stat_ff     <= stat_in;
      pay_ff      <= pay_in;
      rsp_pay_ff  <= rsp_pay_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_free_ff <= rsp_free_in;
   end

endmodule
